FILE: sv/amc_pkg.sv
// Shared constants and operation codes for the multi-pattern byte matcher.
package amc_pkg;

  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_ALPHABET  = 256;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_BUILD  = 2'd2,
    OP_SCAN   = 2'd3
  } op_t;

endpackage

FILE: sv/multi_pattern_byte_matcher_core.sv
// Aho-Corasick byte matcher: trie insert, failure-link build, text scan and clear.
//
// Usage: drive operation, symbol and pattern_end with start high; the item is
// taken at a rising edge where start is high and busy is low. busy then stays
// high until the item's single result appears: done is high for exactly one
// cycle with match_found, node_now and status. The receiver cannot stall.
//
// Steps (all memories have a registered read, one access each per cycle):
//   insert : goto read, then edge/fail/mark writes.
//   scan   : a failure walk, then a mark read; each walk step is one
//            goto plus failure-link read through the shared address unit.
//   build  : the root row first, then per queued node a failure-link read
//            and a row sweep, with a failure walk for each child found.
//   clear  : the goto rows in use are zeroed one entry per cycle.
// Reset: the whole goto table (MAX_NODES*ALPHABET entries) is zeroed one
// entry per cycle with busy high and no result; node_count returns to one and
// both cursors to the root. Failure links and marks are written when a node
// is created, so they need no sweep.
// One multiplier forms node*ALPHABET+symbol for every goto access but the clear sweep.
module multi_pattern_byte_matcher_core #(
  parameter int MAX_NODES = amc_pkg::DEF_MAX_NODES,
  parameter int ALPHABET  = amc_pkg::DEF_ALPHABET
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   operation,
  input  logic [7:0]                   symbol,
  input  logic                         pattern_end,
  output logic                         done,
  output logic                         match_found,
  output logic [$clog2(MAX_NODES)-1:0] node_now,
  output logic                         status
);

  import amc_pkg::*;

  localparam int NW    = $clog2(MAX_NODES);
  localparam int SW    = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
  localparam int GD    = MAX_NODES * ALPHABET;
  localparam int GW    = $clog2(GD);
  localparam int RECIP = (65536 + ALPHABET - 1) / ALPHABET;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_INS_RD, S_INS_CHK, S_SCAN_TERM, S_SCAN_OUT,
    S_B_RISS, S_B_RCHK, S_B_POP, S_B_POPW, S_B_FU, S_B_FUW,
    S_B_EISS, S_B_ECHK, S_B_TX, S_B_TY, S_B_TW, S_F_ISS, S_F_CHK
  } state_t;

  state_t          state, ret;
  logic            flag, emit;
  logic [SW-1:0]   sym_r, bsym;
  logic [NW:0]     count;
  logic [NW-1:0]   cursor, cur, fv, fres, u, fu, x;
  logic [NW-1:0]   head, tail;
  logic            tx;
  logic [GW:0]     clr_addr, clr_limit;

  // symbol reduction by reciprocal multiply
  logic [24:0]     sym_prod;
  logic [8:0]      sym_q;
  logic [16:0]     sym_qa;
  logic [SW-1:0]   sym_red;

  // shared goto address unit
  logic [NW-1:0]   mul_node;
  logic [SW-1:0]   mul_sym;
  logic [GW-1:0]   ga;

  logic            goto_we, fail_we, term_we, queue_we;
  logic [GW-1:0]   goto_waddr;
  logic [NW-1:0]   goto_wdata, goto_rdata;
  logic [NW-1:0]   fail_waddr, fail_wdata, fail_raddr, fail_rdata;
  logic [NW-1:0]   term_waddr, term_raddr;
  logic [0:0]      term_wdata, term_rdata;
  logic [NW-1:0]   queue_rdata;
  logic            full, sym_last;

  assign busy     = (state != S_IDLE);
  assign full     = (count >= (NW+1)'(MAX_NODES));
  assign sym_last = (bsym == SW'(ALPHABET - 1));

  always_comb begin
    sym_prod = 25'(symbol) * 25'(RECIP);
    sym_q    = sym_prod[24:16];
    sym_qa   = 17'(sym_q) * 17'(ALPHABET);
    sym_red  = SW'(17'(symbol) - sym_qa);
  end

  // pick the node/symbol pair for this cycle's goto access
  always_comb begin
    mul_node = '0;
    mul_sym  = '0;
    unique case (state)
      S_INS_RD, S_INS_CHK: begin mul_node = cursor; mul_sym = sym_r; end
      S_F_ISS:             begin mul_node = fv;     mul_sym = bsym;  end
      S_B_RISS:            begin mul_node = '0;     mul_sym = bsym;  end
      S_B_EISS:            begin mul_node = u;      mul_sym = bsym;  end
      default:             begin mul_node = '0;     mul_sym = '0;    end
    endcase
    ga = GW'(GW'(mul_node) * GW'(ALPHABET)) + GW'(mul_sym);
  end

  // memory write and read steering
  always_comb begin
    goto_we    = 1'b0;
    goto_waddr = ga;
    goto_wdata = count[NW-1:0];
    fail_we    = 1'b0;
    fail_waddr = count[NW-1:0];
    fail_wdata = '0;
    term_we    = 1'b0;
    term_waddr = count[NW-1:0];
    term_wdata = 1'(flag);
    queue_we   = 1'b0;
    fail_raddr = u;
    term_raddr = fres;
    unique case (state)
      S_CLR: begin
        goto_we    = 1'b1;
        goto_waddr = clr_addr[GW-1:0];
        goto_wdata = '0;
      end
      S_INS_CHK: begin
        if (goto_rdata == '0) begin
          goto_we = !full;
          fail_we = !full;
          term_we = !full;
        end else begin
          term_we    = flag;
          term_waddr = goto_rdata;
          term_wdata = 1'b1;
        end
      end
      S_B_RCHK: begin
        fail_we    = (goto_rdata != '0);
        fail_waddr = goto_rdata;
        queue_we   = (goto_rdata != '0);
      end
      S_B_TX: begin
        fail_we    = 1'b1;
        fail_waddr = x;
        fail_wdata = fres;
        queue_we   = 1'b1;
        term_raddr = x;
      end
      S_B_TW: begin
        term_we    = 1'b1;
        term_waddr = x;
        term_wdata = 1'(tx | ((fres != '0) & term_rdata[0]));
      end
      S_F_ISS: fail_raddr = fv;
      default: ;
    endcase
  end

  amc_ram #(.WIDTH(NW), .DEPTH(GD)) u_goto (
    .clk(clk), .we(goto_we), .waddr(goto_waddr), .wdata(goto_wdata),
    .raddr(ga), .rdata(goto_rdata)
  );

  amc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
    .clk(clk), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
    .raddr(fail_raddr), .rdata(fail_rdata)
  );

  amc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_term (
    .clk(clk), .we(term_we), .waddr(term_waddr), .wdata(term_wdata),
    .raddr(term_raddr), .rdata(term_rdata)
  );

  amc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(queue_we), .waddr(tail),
    .wdata((state == S_B_TX) ? x : goto_rdata),
    .raddr(head), .rdata(queue_rdata)
  );

  // sequencer: one clocked block for state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_addr    <= '0;
      clr_limit   <= (GW+1)'(GD);
      emit        <= 1'b0;
      done        <= 1'b0;
      count       <= (NW+1)'(1);
      cursor      <= '0;
      cur         <= '0;
      head        <= '0;
      tail        <= '0;
      ret         <= S_IDLE;
      match_found <= 1'b0;
      node_now    <= '0;
      status      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          // a result strobe only ever lands in idle: drop it here
          done <= 1'b0;
          if (start) begin
            sym_r <= sym_red;
            bsym  <= (op_t'(operation) == OP_BUILD) ? '0 : sym_red;
            flag  <= pattern_end;
            unique case (op_t'(operation))
              OP_CLEAR: begin
                clr_addr  <= '0;
                clr_limit <= (GW+1)'(count) * (GW+1)'(ALPHABET);
                emit      <= 1'b1;
                state     <= S_CLR;
              end
              OP_INSERT: state <= S_INS_RD;
              OP_BUILD: begin
                head  <= '0;
                tail  <= '0;
                state <= S_B_RISS;
              end
              OP_SCAN: begin
                fv    <= pattern_end ? '0 : cur;
                ret   <= S_SCAN_TERM;
                state <= S_F_ISS;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr + 1'b1 >= clr_limit) begin
            count  <= (NW+1)'(1);
            cursor <= '0;
            cur    <= '0;
            if (emit) begin
              done        <= 1'b1;
              match_found <= 1'b0;
              node_now    <= '0;
              status      <= 1'b0;
            end
            emit  <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_INS_RD: state <= S_INS_CHK;
        S_INS_CHK: begin
          done        <= 1'b1;
          match_found <= 1'b0;
          status      <= (goto_rdata == '0) && full;
          if (goto_rdata == '0) begin
            if (full) begin
              node_now <= cursor;
              if (flag) begin
                cursor <= '0;
              end
            end else begin
              node_now <= count[NW-1:0];
              cursor   <= flag ? '0 : count[NW-1:0];
              count    <= count + 1'b1;
            end
          end else begin
            node_now <= goto_rdata;
            cursor   <= flag ? '0 : goto_rdata;
          end
          state <= S_IDLE;
        end
        // failure walk: goto and failure link of fv read together
        S_F_ISS: state <= S_F_CHK;
        S_F_CHK: begin
          if (goto_rdata != '0 || fv == '0) begin
            fres  <= goto_rdata;
            state <= ret;
          end else begin
            fv    <= fail_rdata;
            state <= S_F_ISS;
          end
        end
        S_SCAN_TERM: begin
          cur   <= fres;
          state <= S_SCAN_OUT;
        end
        S_SCAN_OUT: begin
          done        <= 1'b1;
          match_found <= (fres != '0) & term_rdata[0];
          node_now    <= fres;
          status      <= 1'b0;
          state       <= S_IDLE;
        end
        // root row: queue depth-one nodes
        S_B_RISS: state <= S_B_RCHK;
        S_B_RCHK: begin
          if (goto_rdata != '0) begin
            tail <= tail + 1'b1;
          end
          if (sym_last) begin
            state <= S_B_POP;
          end else begin
            bsym  <= bsym + 1'b1;
            state <= S_B_RISS;
          end
        end
        S_B_POP: begin
          if (head == tail) begin
            cur         <= '0;
            done        <= 1'b1;
            match_found <= 1'b0;
            node_now    <= '0;
            status      <= 1'b0;
            state       <= S_IDLE;
          end else begin
            head  <= head + 1'b1;
            state <= S_B_POPW;
          end
        end
        S_B_POPW: begin
          u     <= queue_rdata;
          state <= S_B_FU;
        end
        S_B_FU: state <= S_B_FUW;
        S_B_FUW: begin
          fu    <= fail_rdata;
          bsym  <= '0;
          state <= S_B_EISS;
        end
        S_B_EISS: state <= S_B_ECHK;
        S_B_ECHK: begin
          if (goto_rdata == '0) begin
            if (sym_last) begin
              state <= S_B_POP;
            end else begin
              bsym  <= bsym + 1'b1;
              state <= S_B_EISS;
            end
          end else begin
            x     <= goto_rdata;
            fv    <= fu;
            ret   <= S_B_TX;
            state <= S_F_ISS;
          end
        end
        S_B_TX: begin
          tail  <= tail + 1'b1;
          state <= S_B_TY;
        end
        S_B_TY: begin
          tx    <= term_rdata[0];
          state <= S_B_TW;
        end
        S_B_TW: begin
          if (sym_last) begin
            state <= S_B_POP;
          end else begin
            bsym  <= bsym + 1'b1;
            state <= S_B_EISS;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // hold busy the cycle after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after an accepted item");

  // one result per item: never two strobes back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // node count stays within the trie
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= (NW+1)'(1)) && (count <= (NW+1)'(MAX_NODES)))
    else $error("node count out of range");

  // full status only on a strobe
  a_status_strobe: assert property (@(posedge clk) disable iff (rst)
    status && !$stable(status) && status |-> done)
    else $error("status raised without a result");

endmodule

FILE: sv/amc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module amc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
